// ===== hw/rtl/fmoe_pkg.sv =====
// ----------------------------------------------------------------------------
// fmoe_pkg: shared types and helpers for the fm operator envelope
// Phase encoding, register indexes, field widths and the rate step lookup.
// ----------------------------------------------------------------------------
package fmoe_pkg;

    // field widths
    localparam int unsigned LEVEL_W   = 16;
    localparam int unsigned STEP_W    = 15;
    localparam int unsigned CODE_W    = 3;
    localparam int unsigned RIDX_W    = 7;
    localparam int unsigned CFG_ADR_W = 3;
    localparam int unsigned CFG_DAT_W = 7;

    // envelope phase, one-hot
    typedef enum logic [4:0] {
        PH_OFF     = 5'b00001,
        PH_ATTACK  = 5'b00010,
        PH_DECAY   = 5'b00100,
        PH_SUSTAIN = 5'b01000,
        PH_RELEASE = 5'b10000
    } phase_t;

    // phase codes as seen on the result beat
    localparam logic [CODE_W-1:0] CODE_OFF     = 3'd0;
    localparam logic [CODE_W-1:0] CODE_ATTACK  = 3'd1;
    localparam logic [CODE_W-1:0] CODE_DECAY   = 3'd2;
    localparam logic [CODE_W-1:0] CODE_SUSTAIN = 3'd3;
    localparam logic [CODE_W-1:0] CODE_RELEASE = 3'd4;

    // input kinds carried on tuser
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_KEY  = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_ADR_W-1:0] {
        REG_ATTACK_RATE   = 3'd0,
        REG_DECAY_RATE    = 3'd1,
        REG_SUSTAIN_RATE  = 3'd2,
        REG_SUSTAIN_LEVEL = 3'd3,
        REG_RELEASE_RATE  = 3'd4,
        REG_KEY_SCALE     = 3'd5,
        REG_TOTAL_LEVEL   = 3'd6
    } cfg_reg_t;

    localparam logic [RIDX_W-1:0] RIDX_MAX = 7'd63;
    localparam logic [RIDX_W-1:0] RIDX_MIN = 7'd4;

    // rate step: 0 below index 4, else 1 << ((idx-4)/4), index capped at 63
    function automatic logic [STEP_W-1:0] rate_step(input logic [RIDX_W-1:0] idx);
        logic [RIDX_W-1:0] capped;
        logic [RIDX_W-1:0] offs;
        capped = (idx > RIDX_MAX) ? RIDX_MAX : idx;
        offs   = capped - RIDX_MIN;
        if (capped < RIDX_MIN) begin
            rate_step = '0;
        end else begin
            rate_step = STEP_W'(1) << offs[5:2];
        end
    endfunction

    // one-hot phase to output code, stray codes read as off
    function automatic logic [CODE_W-1:0] phase_code(input phase_t ph);
        unique case (ph)
            PH_ATTACK:  phase_code = CODE_ATTACK;
            PH_DECAY:   phase_code = CODE_DECAY;
            PH_SUSTAIN: phase_code = CODE_SUSTAIN;
            PH_RELEASE: phase_code = CODE_RELEASE;
            default:    phase_code = CODE_OFF;
        endcase
    endfunction

endpackage

// ===== hw/rtl/fm_operator_envelope.sv =====
// ----------------------------------------------------------------------------
// fm_operator_envelope: adsr envelope generator for one fm operator
// The result beat is registered and is presented in the cycle after its input beat is accepted.
// Throughput: one item per cycle while m_tready does not stall the result; the envelope state update is a single add,
// compare and clamp that closes in the accepting cycle.
// Reset: synchronous active-low aresetn clears the configuration registers, the phase to
// off, the level and the key flag; no result is pending after reset.
// ----------------------------------------------------------------------------
module fm_operator_envelope (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [fmoe_pkg::CFG_ADR_W-1:0]  cfg_addr,
    input  logic [fmoe_pkg::CFG_DAT_W-1:0]  cfg_wr_data,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // [0] key_bit, [7:1] zero
    input  logic                            s_tuser,  // [0] func
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata   // [15:0] env_level,
                                                      // [18:16] env_phase,
                                                      // [19] phase_restart,
                                                      // [23:20] zero
);

    // configuration registers
    logic [4:0] attack_rate_reg;
    logic [4:0] decay_rate_reg;
    logic [4:0] sustain_rate_reg;
    logic [3:0] sustain_level_reg;
    logic [3:0] release_rate_reg;
    logic [1:0] key_scale_reg;
    logic [6:0] total_level_reg;

    // envelope state
    fmoe_pkg::phase_t                phase_reg, phase_next;
    logic [fmoe_pkg::LEVEL_W-1:0]    level_reg, level_next;
    logic                            key_reg, key_next;
    logic                            restart_next;

    // result register
    logic                            m_valid_reg;
    logic [23:0]                     m_data_reg;

    logic                            in_fire;
    logic [fmoe_pkg::RIDX_W-1:0]     rate_idx;
    logic [fmoe_pkg::STEP_W-1:0]     step;
    logic [fmoe_pkg::LEVEL_W:0]      rise;
    logic [fmoe_pkg::LEVEL_W-1:0]    fall;
    logic [fmoe_pkg::LEVEL_W-1:0]    ceil_lvl;
    logic [fmoe_pkg::LEVEL_W-1:0]    sus_lvl;
    logic                            key_bit;
    logic                            func;

    assign key_bit  = s_tdata[0];
    assign func     = s_tuser;

    // accept while the result slot is empty or being drained
    assign s_tready = !m_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    // configuration writes, unknown indexes dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_rate_reg   <= '0;
            decay_rate_reg    <= '0;
            sustain_rate_reg  <= '0;
            sustain_level_reg <= '0;
            release_rate_reg  <= '0;
            key_scale_reg     <= '0;
            total_level_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (fmoe_pkg::cfg_reg_t'(cfg_addr))
                fmoe_pkg::REG_ATTACK_RATE:   attack_rate_reg   <= cfg_wr_data[4:0];
                fmoe_pkg::REG_DECAY_RATE:    decay_rate_reg    <= cfg_wr_data[4:0];
                fmoe_pkg::REG_SUSTAIN_RATE:  sustain_rate_reg  <= cfg_wr_data[4:0];
                fmoe_pkg::REG_SUSTAIN_LEVEL: sustain_level_reg <= cfg_wr_data[3:0];
                fmoe_pkg::REG_RELEASE_RATE:  release_rate_reg  <= cfg_wr_data[3:0];
                fmoe_pkg::REG_KEY_SCALE:     key_scale_reg     <= cfg_wr_data[1:0];
                fmoe_pkg::REG_TOTAL_LEVEL:   total_level_reg   <= cfg_wr_data[6:0];
                default: ;
            endcase
        end
    end

    // rate index for the current phase
    always_comb begin
        unique case (phase_reg)
            fmoe_pkg::PH_ATTACK:  rate_idx = {1'b0, attack_rate_reg, 1'b0}
                                             + {5'b0, key_scale_reg};
            fmoe_pkg::PH_DECAY:   rate_idx = {1'b0, decay_rate_reg, 1'b0}
                                             + {5'b0, key_scale_reg};
            fmoe_pkg::PH_SUSTAIN: rate_idx = {1'b0, sustain_rate_reg, 1'b0}
                                             + {5'b0, key_scale_reg};
            default:              rate_idx = {1'b0, release_rate_reg, 2'b10}
                                             + {5'b0, key_scale_reg};
        endcase
    end

    assign step     = fmoe_pkg::rate_step(rate_idx);
    assign rise     = {1'b0, level_reg} + {2'b0, step};
    assign fall     = (level_reg > {1'b0, step}) ? (level_reg - {1'b0, step}) : '0;
    assign ceil_lvl = {7'd127 - total_level_reg, 9'b0};
    assign sus_lvl  = {4'd15 - sustain_level_reg, 12'b0};

    // next envelope state for one item
    always_comb begin
        phase_next   = phase_reg;
        level_next   = level_reg;
        key_next     = key_reg;
        restart_next = 1'b0;
        if (func == fmoe_pkg::FUNC_KEY) begin
            if (key_bit) begin
                key_next     = 1'b1;
                phase_next   = fmoe_pkg::PH_ATTACK;
                level_next   = '0;
                restart_next = 1'b1;
            end else begin
                key_next = 1'b0;
                if (phase_reg != fmoe_pkg::PH_OFF) begin
                    phase_next = fmoe_pkg::PH_RELEASE;
                end
            end
        end else begin
            unique case (phase_reg)
                fmoe_pkg::PH_ATTACK: begin
                    if (!key_reg) begin
                        phase_next = fmoe_pkg::PH_RELEASE;
                    end else if (rise >= {1'b0, ceil_lvl}) begin
                        level_next = ceil_lvl;
                        phase_next = fmoe_pkg::PH_DECAY;
                    end else begin
                        // below the ceiling, so it fits sixteen bits
                        level_next = rise[fmoe_pkg::LEVEL_W-1:0];
                    end
                end
                fmoe_pkg::PH_DECAY: begin
                    if (!key_reg) begin
                        phase_next = fmoe_pkg::PH_RELEASE;
                    end else begin
                        level_next = fall;
                        if (fall <= sus_lvl) begin
                            phase_next = fmoe_pkg::PH_SUSTAIN;
                        end
                    end
                end
                fmoe_pkg::PH_SUSTAIN: begin
                    if (!key_reg) begin
                        phase_next = fmoe_pkg::PH_RELEASE;
                    end else begin
                        level_next = fall;
                    end
                end
                fmoe_pkg::PH_RELEASE: begin
                    level_next = fall;
                    if (level_reg <= {1'b0, step}) begin
                        phase_next = fmoe_pkg::PH_OFF;
                    end
                end
                default: begin
                    // off, and any stray code behaves as off
                    if (key_reg) begin
                        phase_next = fmoe_pkg::PH_ATTACK;
                        level_next = '0;
                    end
                end
            endcase
        end
    end

    // state and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= fmoe_pkg::PH_OFF;
            level_reg   <= '0;
            key_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                phase_reg   <= phase_next;
                level_reg   <= level_next;
                key_reg     <= key_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            m_data_reg <= {4'b0, restart_next, fmoe_pkg::phase_code(phase_next),
                           level_next};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
